// ----- src/spsg_pkg.sv -----
// Package for the speed phase segmenter: slope class codes, register indexes,
// register reset values and result queue sizing.
// No dependencies; imported by the segmenter core.
package spsg_pkg;

    typedef enum logic [1:0] {
        CLASS_NONE = 2'd0,
        CLASS_RISE = 2'd1,
        CLASS_FALL = 2'd2,
        CLASS_FLAT = 2'd3
    } slope_class_t;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_STEP_THRESHOLD   = 2'd0,
        CFG_CHANGE_THRESHOLD = 2'd1,
        CFG_MIN_DURATION     = 2'd2
    } cfg_index_t;

    localparam int STEP_THR_BITS = 15;
    localparam int CHG_THR_BITS  = 16;
    localparam int DUR_BITS      = 16;

    localparam logic [STEP_THR_BITS-1:0] STEP_THR_RESET = 15'd64;
    localparam logic [CHG_THR_BITS-1:0]  CHG_THR_RESET  = 16'd256;
    localparam logic [DUR_BITS-1:0]      DUR_RESET      = 16'd10;

    // One tick yields at most three results; the queue keeps room for that.
    localparam int MAX_RESULTS  = 3;
    localparam int QUEUE_DEPTH  = 8;
    localparam int QPTR_BITS    = 3;
    localparam int QCOUNT_BITS  = 4;

endpackage

// ----- src/speed_phase_segmenter_core.sv -----
// Speed phase segmenter core: splits a per-tick speed trace into speed goals.
// Depends on spsg_pkg (slope classes, register indexes, queue sizing).
//
// Usage
//   Input channel (in_valid / in_stall): one transaction per tick carrying
//   speed_sample, sample_valid and final_tick. Output channel (out_valid /
//   out_stall): one transaction per speed goal: segment_start, goal_speed,
//   goal_tick, no_sample_seen and run_end (last goal caused by that tick).
//   Configuration: cfg_we writes cfg_wdata into the register picked by
//   cfg_index (0 step threshold, 1 speed change threshold, 2 minimum
//   duration); other indexes are ignored. Write only while idle.
// Timing
//   A tick is evaluated in the cycle it is accepted against the trace state
//   registers; its goals are registered into an 8-entry result queue that
//   feeds the output. One tick is taken every cycle while in_stall is low.
//   The output drains one goal per cycle while out_stall is low, so a tick
//   with two or three goals (front, segment, final) only costs extra output cycles.
// Flow control
//   in_stall rises when the queue can no longer take the three goals a
//   single tick may produce; a stalled output holds its goal steady.
// Reset
//   rst_n clears the trace state, the queue and loads register defaults.
module speed_phase_segmenter_core #(
    parameter int TICK_BITS  = 24,
    parameter int SPEED_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [spsg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [spsg_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    // tick input
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [SPEED_BITS-1:0]        speed_sample,
    input  logic                                sample_valid,
    input  logic                                final_tick,
    // goal output
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [TICK_BITS-1:0]                segment_start,
    output logic signed [SPEED_BITS-1:0]        goal_speed,
    output logic [TICK_BITS-1:0]                goal_tick,
    output logic                                no_sample_seen,
    output logic                                run_end
);
    import spsg_pkg::*;

    // Compare width for speed differences against the thresholds.
    localparam int CW   = (SPEED_BITS + 2 > CHG_THR_BITS + 2) ? SPEED_BITS + 2
                                                               : CHG_THR_BITS + 2;
    // Compare width for tick spans against the minimum duration.
    localparam int SPW  = (TICK_BITS > DUR_BITS) ? TICK_BITS : DUR_BITS;

    typedef struct packed {
        logic [TICK_BITS-1:0]         seg_start;
        logic signed [SPEED_BITS-1:0] speed;
        logic [TICK_BITS-1:0]         tick;
        logic                         none_seen;
        logic                         last;
    } goal_entry_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [STEP_THR_BITS-1:0] step_thr_reg;
    logic [CHG_THR_BITS-1:0]  chg_thr_reg;
    logic [DUR_BITS-1:0]      min_dur_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_thr_reg <= STEP_THR_RESET;
            chg_thr_reg  <= CHG_THR_RESET;
            min_dur_reg  <= DUR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STEP_THRESHOLD:   step_thr_reg <= cfg_wdata[STEP_THR_BITS-1:0];
                CFG_CHANGE_THRESHOLD: chg_thr_reg  <= cfg_wdata[CHG_THR_BITS-1:0];
                CFG_MIN_DURATION:     min_dur_reg  <= cfg_wdata[DUR_BITS-1:0];
                default:              ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Trace state
    // ------------------------------------------------------------------
    logic [TICK_BITS-1:0]         tick_reg,       tick_next;
    logic signed [SPEED_BITS-1:0] prior_reg,      prior_next;
    logic                         have_prior_reg, have_prior_next;
    slope_class_t                 class_reg,      class_next;
    logic [TICK_BITS-1:0]         seg_tick_reg,   seg_tick_next;
    logic signed [SPEED_BITS-1:0] seg_speed_reg,  seg_speed_next;
    logic                         have_seg_reg,   have_seg_next;
    logic                         emitted_reg,    emitted_next;

    logic in_accept;
    logic out_pop;

    assign in_accept = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Per-tick arithmetic
    // ------------------------------------------------------------------
    logic signed [SPEED_BITS-1:0] seg_speed_eff;
    logic signed [CW-1:0]         v_ext;
    logic signed [CW-1:0]         step_d;
    logic signed [CW-1:0]         step_mag;
    logic signed [CW-1:0]         chg_d;
    logic signed [CW-1:0]         chg_mag;
    logic signed [CW-1:0]         thr_pos;
    logic signed [CW-1:0]         thr_neg;
    logic signed [CW-1:0]         chg_thr;
    slope_class_t                 step_class;
    logic                         big_change;
    logic [TICK_BITS-1:0]         t_prev;
    logic [TICK_BITS-1:0]         span_prev;
    logic [TICK_BITS-1:0]         span_now;
    logic                         dur_ok_prev;
    logic                         dur_ok_now;

    // Segment start speed as it stands once the first sample is taken.
    assign seg_speed_eff = have_seg_reg ? seg_speed_reg : speed_sample;

    assign v_ext    = CW'(speed_sample);
    assign step_d   = v_ext - CW'(prior_reg);
    assign step_mag = (step_d < 0) ? -step_d : step_d;
    assign chg_d    = v_ext - CW'(seg_speed_eff);
    assign chg_mag  = (chg_d < 0) ? -chg_d : chg_d;
    assign thr_pos  = signed'(CW'(step_thr_reg));
    assign thr_neg  = -thr_pos;
    assign chg_thr  = signed'(CW'(chg_thr_reg));

    assign big_change = chg_mag >= chg_thr;

    always_comb
    begin
        if (step_d >= thr_pos)
            step_class = CLASS_RISE;
        else if (step_d <= thr_neg)
            step_class = CLASS_FALL;
        else
            step_class = CLASS_FLAT;
    end

    // Spans wrap modulo the tick range and compare as unsigned.
    assign t_prev      = tick_reg - TICK_BITS'(1);
    assign span_prev   = t_prev - seg_tick_reg;
    assign span_now    = tick_reg - seg_tick_reg;
    assign dur_ok_prev = SPW'(span_prev) >= SPW'(min_dur_reg);
    assign dur_ok_now  = SPW'(span_now) >= SPW'(min_dur_reg);

    // ------------------------------------------------------------------
    // Sample step: state after the sample, and whether a goal falls out
    // ------------------------------------------------------------------
    logic                         s_emit;
    logic [TICK_BITS-1:0]         s_goal_tick;
    logic                         s_new_seg;
    logic                         run_ended;
    logic                         run_reversed;
    logic signed [SPEED_BITS-1:0] prior_s;
    logic                         have_prior_s;
    slope_class_t                 class_s;
    logic [TICK_BITS-1:0]         seg_tick_s;
    logic signed [SPEED_BITS-1:0] seg_speed_s;
    logic                         have_seg_s;
    logic                         emitted_s;

    always_comb
    begin
        s_emit       = 1'b0;
        s_goal_tick  = tick_reg;
        s_new_seg    = 1'b0;
        run_ended    = 1'b0;
        run_reversed = 1'b0;
        prior_s      = prior_reg;
        have_prior_s = have_prior_reg;
        class_s      = class_reg;
        have_seg_s   = have_seg_reg;
        seg_speed_s  = seg_speed_reg;

        if (sample_valid)
        begin
            have_seg_s  = 1'b1;
            seg_speed_s = seg_speed_eff;
            if (!have_prior_reg)
            begin
                prior_s      = speed_sample;
                have_prior_s = 1'b1;
            end
            else if (class_reg == CLASS_NONE)
            begin
                prior_s = speed_sample;
                class_s = step_class;
            end
            else
            begin
                case (class_reg) inside
                    CLASS_RISE, CLASS_FALL:
                    begin
                        if (class_reg == CLASS_RISE)
                        begin
                            run_ended    = step_d < thr_pos;
                            run_reversed = step_d <= thr_neg;
                        end
                        else
                        begin
                            run_ended    = step_d > thr_neg;
                            run_reversed = step_d >= thr_pos;
                        end
                        if (run_ended)
                        begin
                            if (dur_ok_prev && big_change)
                            begin
                                s_emit      = 1'b1;
                                s_goal_tick = t_prev;
                                s_new_seg   = 1'b1;
                            end
                            if (run_reversed)
                                s_new_seg = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (step_mag >= thr_pos)
                            s_new_seg = 1'b1;
                        else if (dur_ok_now && big_change)
                        begin
                            s_emit      = 1'b1;
                            s_goal_tick = tick_reg;
                            s_new_seg   = 1'b1;
                        end
                    end
                endcase
                prior_s = speed_sample;
                class_s = step_class;
            end
        end

        // A new segment starts one tick back, at the previous speed.
        seg_tick_s = s_new_seg ? t_prev : seg_tick_reg;
        if (s_new_seg)
            seg_speed_s = prior_reg;
        emitted_s = emitted_reg || s_emit;
    end

    // ------------------------------------------------------------------
    // Goal list for this tick: front, segment goal, front, final goal
    // ------------------------------------------------------------------
    goal_entry_t      res [MAX_RESULTS];
    logic [1:0]       res_count;
    goal_entry_t      front_s;
    goal_entry_t      goal_s;
    goal_entry_t      front_f;
    goal_entry_t      goal_f;
    logic             front_s_hit;
    logic             front_f_hit;

    always_comb
    begin
        front_s   = '{seg_start: '0, speed: seg_speed_eff, tick: seg_tick_reg,
                      none_seen: 1'b0, last: 1'b0};
        goal_s    = '{seg_start: seg_tick_reg, speed: speed_sample, tick: s_goal_tick,
                      none_seen: 1'b0, last: 1'b0};
        front_f   = '{seg_start: '0, speed: seg_speed_s, tick: seg_tick_s,
                      none_seen: 1'b0, last: 1'b0};
        goal_f    = '{seg_start: seg_tick_s,
                      speed: have_prior_s ? prior_s : '0,
                      tick: tick_reg, none_seen: !have_prior_s, last: 1'b0};

        front_s_hit = s_emit && !emitted_reg && (seg_tick_reg != '0);
        front_f_hit = final_tick && !emitted_s && (seg_tick_s != '0);

        for (int k = 0; k < MAX_RESULTS; k++)
            res[k] = goal_s;
        res_count = 2'd0;

        if (front_s_hit)
        begin
            res[res_count] = front_s;
            res_count      = res_count + 2'd1;
        end
        if (s_emit)
        begin
            res[res_count] = goal_s;
            res_count      = res_count + 2'd1;
        end
        if (front_f_hit)
        begin
            res[res_count] = front_f;
            res_count      = res_count + 2'd1;
        end
        if (final_tick)
        begin
            res[res_count] = goal_f;
            res_count      = res_count + 2'd1;
        end
        // Mark the last goal caused by this tick.
        if (res_count != 2'd0)
            res[res_count - 2'd1].last = 1'b1;
    end

    // ------------------------------------------------------------------
    // State update: advance on every accepted tick, clear at trace end
    // ------------------------------------------------------------------
    always_comb
    begin
        tick_next       = tick_reg;
        prior_next      = prior_reg;
        have_prior_next = have_prior_reg;
        class_next      = class_reg;
        seg_tick_next   = seg_tick_reg;
        seg_speed_next  = seg_speed_reg;
        have_seg_next   = have_seg_reg;
        emitted_next    = emitted_reg;

        if (in_accept)
        begin
            if (final_tick)
            begin
                tick_next       = '0;
                prior_next      = '0;
                have_prior_next = 1'b0;
                class_next      = CLASS_NONE;
                seg_tick_next   = '0;
                seg_speed_next  = '0;
                have_seg_next   = 1'b0;
                emitted_next    = 1'b0;
            end
            else
            begin
                tick_next       = tick_reg + TICK_BITS'(1);
                prior_next      = prior_s;
                have_prior_next = have_prior_s;
                class_next      = class_s;
                seg_tick_next   = seg_tick_s;
                seg_speed_next  = seg_speed_s;
                have_seg_next   = have_seg_s;
                emitted_next    = emitted_s;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg       <= '0;
            prior_reg      <= '0;
            have_prior_reg <= 1'b0;
            class_reg      <= CLASS_NONE;
            seg_tick_reg   <= '0;
            seg_speed_reg  <= '0;
            have_seg_reg   <= 1'b0;
            emitted_reg    <= 1'b0;
        end
        else
        begin
            tick_reg       <= tick_next;
            prior_reg      <= prior_next;
            have_prior_reg <= have_prior_next;
            class_reg      <= class_next;
            seg_tick_reg   <= seg_tick_next;
            seg_speed_reg  <= seg_speed_next;
            have_seg_reg   <= have_seg_next;
            emitted_reg    <= emitted_next;
        end
    end

    // ------------------------------------------------------------------
    // Result queue: up to three pushes and, unless out_stall is high, one pop per cycle
    // ------------------------------------------------------------------
    goal_entry_t            queue_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg,  wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg,  rd_ptr_next;
    logic [QCOUNT_BITS-1:0] count_reg,   count_next;
    logic [1:0]             push_count;
    goal_entry_t            head;

    assign push_count = in_accept ? res_count : 2'd0;
    assign out_valid  = count_reg != '0;
    assign out_pop    = out_valid && !out_stall;

    // Hold off input once the queue cannot absorb a worst-case tick.
    assign in_stall = count_reg > QCOUNT_BITS'(QUEUE_DEPTH - MAX_RESULTS);

    assign wr_ptr_next = wr_ptr_reg + QPTR_BITS'(push_count);
    assign rd_ptr_next = rd_ptr_reg + QPTR_BITS'(out_pop);
    assign count_next  = count_reg + QCOUNT_BITS'(push_count)
                         - QCOUNT_BITS'(out_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (2'(k) < push_count)
                queue_mem[wr_ptr_reg + QPTR_BITS'(k)] <= res[k];
        end
    end

    assign head           = queue_mem[rd_ptr_reg];
    assign segment_start  = head.seg_start;
    assign goal_speed     = head.speed;
    assign goal_tick      = head.tick;
    assign no_sample_seen = head.none_seen;
    assign run_end        = head.last;

endmodule

// ----- src/spsg_checker.sv -----
// Port-level checker for the speed phase segmenter core, bound into the core.
// Depends on speed_phase_segmenter_core's port list.
module spsg_checker #(
    parameter int TICK_BITS  = 24,
    parameter int SPEED_BITS = 16
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [TICK_BITS-1:0]         segment_start,
    input logic signed [SPEED_BITS-1:0] goal_speed,
    input logic [TICK_BITS-1:0]         goal_tick,
    input logic                         no_sample_seen,
    input logic                         run_end
);

    // A stalled goal stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(segment_start)
            && $stable(goal_speed) && $stable(goal_tick)
            && $stable(no_sample_seen) && $stable(run_end))
        else $error("stalled goal changed");

    // An empty queue never holds off the input.
    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty queue");

    // Input stall only follows a queue that was already holding goals.
    a_stall_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> $past(out_valid))
        else $error("input stall without queued goals");

    // A trace without samples ends in one zero-speed final goal.
    a_no_sample_goal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_sample_seen |-> goal_speed == '0 && run_end
            && segment_start == '0)
        else $error("bad goal for a trace without samples");

endmodule

bind speed_phase_segmenter_core spsg_checker #(
    .TICK_BITS  (TICK_BITS),
    .SPEED_BITS (SPEED_BITS)
) u_spsg_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .segment_start  (segment_start),
    .goal_speed     (goal_speed),
    .goal_tick      (goal_tick),
    .no_sample_seen (no_sample_seen),
    .run_end        (run_end)
);
